[rtl/core/sdg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdg_pkg: shared definitions for the saturating drive with gate
// Widths, register codes, controller commands and arithmetic helpers.
// ----------------------------------------------------------------------------
package sdg_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int NUM_CHANNELS = 2;
    localparam int FRAC         = SAMPLE_BITS - 1;
    localparam int GATE_BITS    = 23;
    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int A_W       = FRAC + 4;
    localparam int DIV_NUM_W = 2 * FRAC + 1;
    localparam int DIV_DEN_W = FRAC + 5;
    localparam int DIV_Q_W   = FRAC + 1;
    localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

    localparam int MA_W  = FRAC + 3;
    localparam int MB_W  = 18;
    localparam int P_W   = MA_W + MB_W;
    localparam int GAIN_W = 17;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);
    localparam logic [FRAC-1:0] HARD_LIM =
        FRAC'(((64'd1 << (FRAC + 2)) + 64'd5) / 64'd10);

    localparam logic signed [P_W-1:0] SAT_HI = (P_W'(1) << FRAC) - P_W'(1);
    localparam logic signed [P_W-1:0] SAT_LO = -SAT_HI - P_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DRIVE_ENABLE   = 3'd0,
        REG_MIX_AMOUNT     = 3'd1,
        REG_FIRST_DRIVE    = 3'd2,
        REG_SECOND_DRIVE   = 3'd3,
        REG_GATE_THRESHOLD = 3'd4,
        REG_GATE_KNEE_TOP  = 3'd5,
        REG_ATTACK_RATE    = 3'd6,
        REG_RELEASE_RATE   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic                 drive_enable;
        logic [15:0]          mix_amount;
        logic [15:0]          first_drive;
        logic [15:0]          second_drive;
        logic [GATE_BITS-1:0] gate_threshold;
        logic [GATE_BITS-1:0] gate_knee_top;
        logic [15:0]          attack_rate;
        logic [15:0]          release_rate;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic mul_a;
        logic div_q_start;
        logic soft_load;
        logic mul_hard;
        logic mul_mix;
        logic mul_env;
        logic gate;
        logic div_r_start;
        logic mul_g;
        logic mul_out;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic enable;
        logic div_done;
        logic gate_div;
        logic out_busy;
    } status_t;

    // Moves a gate register from its own fraction width to the sample fraction width.
    function automatic logic [FRAC-1:0] to_frac(input logic [GATE_BITS-1:0] r);
        logic [GATE_BITS+FRAC-1:0] w;
        w = {r, {FRAC{1'b0}}} >> GATE_BITS;
        return w[FRAC-1:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [P_W-1:0] v);
        logic signed [P_W-1:0] c;
        if (v > SAT_HI)
            c = SAT_HI;
        else if (v < SAT_LO)
            c = SAT_LO;
        else
            c = v;
        return c[SAMPLE_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

[rtl/core/sdg_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdg_if: channel interfaces
// Sample input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface sdg_in_if import sdg_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          channel_in;
    modport source (output valid, sample_in, channel_in, input ready);
    modport sink   (input valid, sample_in, channel_in, output ready);
endinterface

interface sdg_out_if import sdg_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          channel_out;
    modport source (output valid, sample_out, channel_out, input ready);
    modport sink   (input valid, sample_out, channel_out, output ready);
endinterface

interface sdg_cfg_if import sdg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/core/sdg_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdg_div: iterative restoring divider
// One quotient bit per cycle; done while the step counter is zero.
// ----------------------------------------------------------------------------
module sdg_div import sdg_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [DIV_NUM_W-1:0] num,
    input  wire logic [DIV_DEN_W-1:0] den,
    output      logic                 done,
    output      logic [DIV_Q_W-1:0]   quot
);

    logic [DIV_DEN_W:0]   rem_reg, rem_next;
    logic [DIV_Q_W-1:0]   q_reg, q_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_DEN_W:0]   shifted;
    logic                 ge;

    always_comb
    begin
        shifted  = {rem_reg[DIV_DEN_W-1:0], q_reg[DIV_Q_W-1]};
        ge       = shifted >= {1'b0, den_reg};
        rem_next = rem_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            // The numerator's upper part is below the divisor, so the quotient fits.
            rem_next = (DIV_DEN_W + 1)'(num >> DIV_Q_W);
            q_next   = num[DIV_Q_W-1:0];
            cnt_next = DIV_CNT_W'(DIV_Q_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next = ge ? (shifted - {1'b0, den_reg}) : shifted;
            q_next   = {q_reg[DIV_Q_W-2:0], ge};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (start)
            den_reg <= den;
    end

    assign done = (cnt_reg == '0);
    assign quot = q_reg;

endmodule
`default_nettype wire

[rtl/core/sdg_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdg_ctrl: sequencing state machine
// Steps one sample through the datapath and hands off the result.
// ----------------------------------------------------------------------------
module sdg_ctrl import sdg_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output      logic    in_ready,
    input  wire status_t status,
    output      cmd_t    cmd
);

    typedef enum logic [11:0] {
        S_IDLE      = 12'b0000_0000_0001,
        S_MULA      = 12'b0000_0000_0010,
        S_DIVQ_GO   = 12'b0000_0000_0100,
        S_DIVQ_WAIT = 12'b0000_0000_1000,
        S_HARD      = 12'b0000_0001_0000,
        S_MIX       = 12'b0000_0010_0000,
        S_ENV       = 12'b0000_0100_0000,
        S_GATE      = 12'b0000_1000_0000,
        S_DIVR_WAIT = 12'b0001_0000_0000,
        S_MULG      = 12'b0010_0000_0000,
        S_OUT       = 12'b0100_0000_0000,
        S_DONE      = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.enable ? S_MULA : S_DONE;
                end
            end
            S_MULA:
            begin
                cmd.mul_a  = 1'b1;
                state_next = S_DIVQ_GO;
            end
            S_DIVQ_GO:
            begin
                cmd.div_q_start = 1'b1;
                state_next      = S_DIVQ_WAIT;
            end
            S_DIVQ_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.soft_load = 1'b1;
                    state_next    = S_HARD;
                end
            end
            S_HARD:
            begin
                cmd.mul_hard = 1'b1;
                state_next   = S_MIX;
            end
            S_MIX:
            begin
                cmd.mul_mix = 1'b1;
                state_next  = S_ENV;
            end
            S_ENV:
            begin
                cmd.mul_env = 1'b1;
                state_next  = S_GATE;
            end
            S_GATE:
            begin
                cmd.gate = 1'b1;
                if (status.gate_div)
                begin
                    cmd.div_r_start = 1'b1;
                    state_next      = S_DIVR_WAIT;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DIVR_WAIT:
            begin
                if (status.div_done)
                    state_next = S_MULG;
            end
            S_MULG:
            begin
                cmd.mul_g  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.mul_out = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid && !status.enable) |=> (state_reg == S_DONE))
        else $error("disabled transaction did not bypass processing");

    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVQ_GO) |=> (state_reg == S_DIVQ_WAIT && !status.div_done))
        else $error("divider reported done right after start");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && status.out_busy) |=> (state_reg == S_DONE))
        else $error("result left while output register was occupied");

endmodule
`default_nettype wire

[rtl/core/sdg_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdg_dp: drive, clip, blend, envelope and gate datapath
// One shared multiplier and one shared divider, steered by controller commands.
// ----------------------------------------------------------------------------
module sdg_dp import sdg_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cfg_t                          cfg,
    input  wire cmd_t                          cmd,
    output      status_t                       status,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
    input  wire logic                          channel_in,
    input  wire logic                          out_ready,
    output      logic                          out_valid,
    output      logic signed [SAMPLE_BITS-1:0] sample_out,
    output      logic                          channel_out
);

    logic signed [SAMPLE_BITS-1:0] x_reg, st2_reg, st2_next, mixed_reg, res_reg;
    logic                          ch_reg;
    logic [A_W-1:0]                a_reg;
    logic [FRAC:0]                 soft_reg;
    logic [SAMPLE_BITS-1:0]        env_reg, env_next;
    logic [SAMPLE_BITS-1:0]        env_mem [NUM_CHANNELS];
    logic [GAIN_W-1:0]             g_reg, g_next;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic                          out_ch_reg;

    logic [CH_W-1:0]               ch_idx;
    logic [FRAC:0]                 mag;
    logic [SAMPLE_BITS-1:0]        absm, env_old;
    logic                          rising;
    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [MA_W-1:0]        ma;
    logic signed [MB_W-1:0]        mb;
    logic signed [P_W-1:0]         prod, prod_rnd;
    logic [P_W-1:0]                prod_u;
    logic [P_W-1:0]                hard_full;
    logic [FRAC-1:0]               hard;
    logic [FRAC-1:0]               thr, knee;
    logic [SAMPLE_BITS-1:0]        thr_x, knee_x;
    logic                          knee_le;

    logic                          div_start;
    logic [DIV_NUM_W-1:0]          div_num;
    logic [DIV_DEN_W-1:0]          div_den, den_q;
    logic                          div_done;
    logic [DIV_Q_W-1:0]            quot;

    assign ch_idx  = (NUM_CHANNELS > 1) ? CH_W'(ch_reg) : '0;
    assign mag     = x_reg[SAMPLE_BITS-1] ? (FRAC + 1)'(-x_reg) : (FRAC + 1)'(x_reg);
    assign absm    = mixed_reg[SAMPLE_BITS-1] ? SAMPLE_BITS'(-mixed_reg)
                                              : SAMPLE_BITS'(mixed_reg);
    assign env_old = env_mem[ch_idx];
    assign rising  = absm > env_old;
    assign diff    = (SAMPLE_BITS + 1)'(st2_reg) - (SAMPLE_BITS + 1)'(x_reg);

    assign thr     = to_frac(cfg.gate_threshold);
    assign knee    = to_frac(cfg.gate_knee_top);
    assign thr_x   = SAMPLE_BITS'(thr);
    assign knee_x  = SAMPLE_BITS'(knee);
    assign knee_le = knee <= thr;

    // Operand steering for the shared multiplier.
    always_comb
    begin
        ma = '0;
        mb = '0;
        if (cmd.mul_a)
        begin
            ma = MA_W'(mag);
            mb = MB_W'(cfg.first_drive);
        end
        else if (cmd.mul_hard)
        begin
            ma = MA_W'(soft_reg);
            mb = MB_W'(cfg.second_drive);
        end
        else if (cmd.mul_mix)
        begin
            ma = MA_W'(diff);
            mb = MB_W'(cfg.mix_amount);
        end
        else if (cmd.mul_env)
        begin
            ma = rising ? MA_W'(absm - env_old) : MA_W'(env_old);
            mb = rising ? MB_W'(cfg.attack_rate) : MB_W'(cfg.release_rate);
        end
        else if (cmd.mul_g)
        begin
            ma = MA_W'(quot[GAIN_W-1:0]);
            mb = MB_W'(quot[GAIN_W-1:0]);
        end
        else if (cmd.mul_out)
        begin
            ma = MA_W'(mixed_reg);
            mb = MB_W'(g_reg);
        end
    end

    assign prod     = P_W'(ma) * P_W'(mb);
    assign prod_u   = prod;
    assign prod_rnd = (prod + $signed(P_W'(32768))) >>> 16;

    assign hard_full = (prod_u + P_W'(8192)) >> 14;
    assign hard      = (hard_full > P_W'(HARD_LIM)) ? HARD_LIM : hard_full[FRAC-1:0];
    assign st2_next  = x_reg[SAMPLE_BITS-1] ? -SAMPLE_BITS'(hard) : SAMPLE_BITS'(hard);

    assign env_next = rising ? (env_old + SAMPLE_BITS'((prod_u + P_W'(32768)) >> 16))
                             : SAMPLE_BITS'((prod_u + P_W'(32768)) >> 16);

    always_comb
    begin
        if (knee_le)
            g_next = (env_reg > thr_x) ? GAIN_ONE : '0;
        else if (env_reg <= thr_x)
            g_next = '0;
        else
            g_next = GAIN_ONE;
    end

    assign den_q     = DIV_DEN_W'((DIV_DEN_W)'(1) << FRAC) + DIV_DEN_W'(a_reg);
    assign div_start = cmd.div_q_start | cmd.div_r_start;
    assign div_den   = cmd.div_r_start ? DIV_DEN_W'(knee - thr) : den_q;
    assign div_num   = cmd.div_r_start
                     ? DIV_NUM_W'({(env_reg - thr_x), 16'd0})
                     : ((DIV_NUM_W'(1) << (2 * FRAC)) + DIV_NUM_W'(den_q >> 1));

    sdg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (quot)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg   <= sample_in;
            ch_reg  <= channel_in;
            res_reg <= sample_in;
        end
        if (cmd.mul_a)
            a_reg <= A_W'((prod_u + P_W'(2048)) >> 12);
        if (cmd.soft_load)
            soft_reg <= ((FRAC + 1)'(1) << FRAC) - quot;
        if (cmd.mul_hard)
            st2_reg <= st2_next;
        if (cmd.mul_mix)
            mixed_reg <= sat_sample(P_W'(x_reg) + prod_rnd);
        if (cmd.mul_env)
            env_reg <= env_next;
        if (cmd.gate && !status.gate_div)
            g_reg <= g_next;
        if (cmd.mul_g)
            g_reg <= GAIN_W'((prod_u + P_W'(32768)) >> 16);
        if (cmd.mul_out)
            res_reg <= sat_sample(prod_rnd);
        if (cmd.out_load)
        begin
            out_sample_reg <= res_reg;
            out_ch_reg     <= ch_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
                env_mem[i] <= '0;
        end
        else
        begin
            if (cmd.mul_env)
                env_mem[ch_idx] <= env_next;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.enable   = cfg.drive_enable;
    assign status.div_done = div_done;
    assign status.gate_div = !knee_le && (env_reg > thr_x) && (env_reg < knee_x);
    assign status.out_busy = out_valid_reg && !out_ready;

    assign out_valid   = out_valid_reg;
    assign sample_out  = out_sample_reg;
    assign channel_out = out_ch_reg;

endmodule
`default_nettype wire

[rtl/core/saturating_drive_with_gate_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// A bypassed sample (drive disabled) goes from acceptance to the output register;
// a processed one also takes one pass of the 24-step divider, or two when the envelope
// sits inside the gate knee. No new sample is taken until the last one is handed off.
// A new sample is accepted while the previous result waits in the output register.
// Reset (rst_n low, asynchronous) loads the register defaults and zeroes both envelopes.
// ----------------------------------------------------------------------------
// saturating_drive_with_gate_unit: soft clip drive with envelope noise gate
// Configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
module saturating_drive_with_gate_unit import sdg_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    sdg_in_if.sink    samples,
    sdg_out_if.source results,
    sdg_cfg_if.sink   cfg
);

    cfg_t    cfg_reg;
    cmd_t    cmd;
    status_t status;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drive_enable   <= 1'b1;
            cfg_reg.mix_amount     <= 16'd16384;
            cfg_reg.first_drive    <= 16'd5456;
            cfg_reg.second_drive   <= 16'd17549;
            cfg_reg.gate_threshold <= GATE_BITS'(83886);
            cfg_reg.gate_knee_top  <= GATE_BITS'(419430);
            cfg_reg.attack_rate    <= 16'd19661;
            cfg_reg.release_rate   <= 16'd65503;
        end
        else if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                REG_DRIVE_ENABLE:   cfg_reg.drive_enable   <= cfg.data[0];
                REG_MIX_AMOUNT:     cfg_reg.mix_amount     <= cfg.data[15:0];
                REG_FIRST_DRIVE:    cfg_reg.first_drive    <= cfg.data[15:0];
                REG_SECOND_DRIVE:   cfg_reg.second_drive   <= cfg.data[15:0];
                REG_GATE_THRESHOLD: cfg_reg.gate_threshold <= cfg.data[GATE_BITS-1:0];
                REG_GATE_KNEE_TOP:  cfg_reg.gate_knee_top  <= cfg.data[GATE_BITS-1:0];
                REG_ATTACK_RATE:    cfg_reg.attack_rate    <= cfg.data[15:0];
                REG_RELEASE_RATE:   cfg_reg.release_rate   <= cfg.data[15:0];
                default:            cfg_reg.drive_enable   <= cfg_reg.drive_enable;
            endcase
        end
    end

    sdg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .status   (status),
        .cmd      (cmd)
    );

    sdg_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .cmd         (cmd),
        .status      (status),
        .sample_in   (samples.sample_in),
        .channel_in  (samples.channel_in),
        .out_ready   (results.ready),
        .out_valid   (results.valid),
        .sample_out  (results.sample_out),
        .channel_out (results.channel_out)
    );

endmodule
`default_nettype wire
